@@ rtl/deck_shuffle_draw_core_defines.svh @@
// Assertion macros for the deck shuffle draw datapath
`ifndef DECK_SHUFFLE_DRAW_CORE_DEFINES_SVH
`define DECK_SHUFFLE_DRAW_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define DSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante
`define DSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dsd_pkg.sv @@
// Shared constants, types and sequencer codes for the deck shuffle draw block
package dsd_pkg;

  localparam int CARDS_PER_DECK = 52;
  localparam int RANKS          = 13;
  localparam int SUITS          = 4;
  localparam int DEF_MAX_DECKS  = 10;
  localparam int RAND_W         = 31;
  localparam int RANK_W         = 4;
  localparam int SUIT_W         = 2;
  localparam int DECK_W         = 4;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [SUIT_W-1:0] suit;
  } card_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RELOAD,
    S_MOD,
    S_READ,
    S_CAPT,
    S_SHIFT,
    S_FIN
  } dsd_state_t;

  typedef struct packed {
    logic accept;
    logic reload_step;
    logic mod_step;
    logic read_idx;
    logic capture;
    logic shift_step;
    logic finish;
  } dsd_cmd_t;

  typedef struct packed {
    logic need_reload;
    logic reload_last;
    logic mod_last;
    logic shift_needed;
    logic shift_last;
    logic out_free;
  } dsd_status_t;

endpackage

@@ rtl/dsd_ctrl.sv @@
// Sequencer for the deck shuffle draw block: reload, modulo, read, gap close, output
module dsd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dsd_pkg::dsd_status_t st,
  output dsd_pkg::dsd_cmd_t    cmd
);
  import dsd_pkg::*;

  dsd_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = st.need_reload ? S_RELOAD : S_MOD;
        end
      end
      S_RELOAD: begin
        cmd.reload_step = 1'b1;
        if (st.reload_last) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read_idx = 1'b1;
        state_next   = S_CAPT;
      end
      S_CAPT: begin
        cmd.capture = 1'b1;
        state_next  = st.shift_needed ? S_SHIFT : S_FIN;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (st.shift_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/dsd_datapath.sv @@
// Datapath for the deck shuffle draw block: card store, modulo unit, output register
module dsd_datapath #(
  parameter int MAX_DECKS = dsd_pkg::DEF_MAX_DECKS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [dsd_pkg::DECK_W-1:0]    cfg_wr_data,
  input  logic [dsd_pkg::RAND_W-1:0]    random_value,
  input  dsd_pkg::dsd_cmd_t             cmd,
  output dsd_pkg::dsd_status_t          st,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dsd_pkg::RANK_W-1:0]    card_rank,
  output logic [dsd_pkg::SUIT_W-1:0]    card_suit,
  output logic                          pass_done
);
  import dsd_pkg::*;
  `include "deck_shuffle_draw_core_defines.svh"

  localparam int STORE_DEPTH = MAX_DECKS * CARDS_PER_DECK;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = $clog2(STORE_DEPTH + 1);
  localparam int BW          = $clog2(RAND_W);

  logic [DECK_W-1:0] deck_count;
  logic [DECK_W:0]   decks_ext;
  logic [DECK_W:0]   decks_clamped;
  logic [CW-1:0]     total;
  logic [CW-1:0]     cards_left;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     ptr_p1;
  logic [AW-1:0]     ptr_p2;
  logic [RANK_W-1:0] rank_cnt;
  logic [SUIT_W-1:0] suit_cnt;
  logic [RAND_W-1:0] rnd;
  logic [CW-1:0]     rem;
  logic [CW:0]       rem_sh;
  logic [BW-1:0]     bit_cnt;
  logic              load_deck;
  card_t             mem [STORE_DEPTH];
  card_t             rd_data;
  card_t             wr_data;
  card_t             drawn;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;

  // Deck count register
  always_ff @(posedge clk) begin
    if (rst) begin
      deck_count <= DECK_W'(1);
    end else if (cfg_wr_en) begin
      deck_count <= cfg_wr_data;
    end
  end

  // Clamp deck count and size the pass
  always_comb begin
    decks_ext = {1'b0, deck_count};
    if (deck_count == '0) begin
      decks_clamped = (DECK_W+1)'(1);
    end else if (decks_ext > (DECK_W+1)'(MAX_DECKS)) begin
      decks_clamped = (DECK_W+1)'(MAX_DECKS);
    end else begin
      decks_clamped = decks_ext;
    end
    total = CW'(decks_clamped * CARDS_PER_DECK);
  end

  assign load_deck = cmd.accept && st.need_reload;
  assign ptr_p1    = ptr + AW'(1);
  assign ptr_p2    = ptr + AW'(2);
  assign rem_sh    = {rem, rnd[RAND_W-1]};

  // Remaining card count
  always_ff @(posedge clk) begin
    if (rst) begin
      cards_left <= '0;
    end else if (load_deck) begin
      cards_left <= total;
    end else if (cmd.finish) begin
      cards_left <= cards_left - CW'(1);
    end
  end

  // Store pointer and reload rank/suit counters
  always_ff @(posedge clk) begin
    if (load_deck) begin
      ptr      <= '0;
      rank_cnt <= '0;
      suit_cnt <= '0;
    end else if (cmd.reload_step) begin
      ptr <= ptr_p1;
      if (rank_cnt == RANK_W'(RANKS - 1)) begin
        rank_cnt <= '0;
        suit_cnt <= suit_cnt + SUIT_W'(1);
      end else begin
        rank_cnt <= rank_cnt + RANK_W'(1);
      end
    end else if (cmd.read_idx) begin
      ptr <= rem[AW-1:0];
    end else if (cmd.shift_step) begin
      ptr <= ptr_p1;
    end
  end

  // Restoring modulo, one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rnd     <= random_value;
      rem     <= '0;
      bit_cnt <= '0;
    end else if (cmd.mod_step) begin
      rnd     <= {rnd[RAND_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BW'(1);
      if (rem_sh >= {1'b0, cards_left}) begin
        rem <= CW'(rem_sh - {1'b0, cards_left});
      end else begin
        rem <= rem_sh[CW-1:0];
      end
    end
  end

  // Store port selection
  always_comb begin
    wr_en = cmd.reload_step || cmd.shift_step;
    if (cmd.reload_step) begin
      wr_data = '{rank: rank_cnt, suit: suit_cnt};
    end else begin
      wr_data = rd_data;
    end
    if (cmd.read_idx) begin
      rd_addr = rem[AW-1:0];
    end else if (cmd.capture) begin
      rd_addr = ptr_p1;
    end else begin
      rd_addr = ptr_p2;
    end
  end

  // Card store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Hold the drawn card
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      drawn <= rd_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      card_rank <= drawn.rank;
      card_suit <= drawn.suit;
      pass_done <= (cards_left == CW'(1));
    end
  end

  // Status to the sequencer
  always_comb begin
    st.need_reload  = (cards_left == '0) || (cards_left > CW'(STORE_DEPTH));
    st.reload_last  = (CW'(ptr) == cards_left - CW'(1));
    st.mod_last     = (bit_cnt == BW'(RAND_W - 1));
    st.shift_needed = (CW'(ptr) != cards_left - CW'(1));
    st.shift_last   = (CW'(ptr) == cards_left - CW'(2));
    st.out_free     = !out_valid || !out_stall;
  end

  `DSD_ASSERT_NOW(a_left_range, 1'b1, cards_left <= CW'(STORE_DEPTH), "cards_left overflow")
  `DSD_ASSERT_NOW(a_shift_bound, cmd.shift_step, (CW'(ptr) + CW'(1)) < cards_left, "shift past end")
  `DSD_ASSERT_NEXT(a_finish_dec, cmd.finish, cards_left == $past(cards_left) - CW'(1), "no decrement")
  `DSD_ASSERT_NEXT(a_finish_out, cmd.finish, out_valid, "finished beat not presented")

endmodule

@@ rtl/deck_shuffle_draw_core.sv @@
// Top level of the deck shuffle draw block: draws cards without replacement
//
// Usage:
//   Configuration: cfg_wr_en with cfg_wr_data sets the number of 52-card decks
//   per pass (0 reads as 1, above MAX_DECKS reads as MAX_DECKS); it is sampled
//   only when the card list reloads at the first draw of a pass.
//   Input channel: in_valid / in_stall / random_value. Each accepted beat draws
//   one card at index random_value mod cards remaining.
//   Output channel: out_valid / out_stall / card_rank, card_suit, pass_done.
//   pass_done marks the last card of the pass; the next draw reloads.
// Draw sequence:
//   After the input beat a draw runs a bit-serial modulo over the 31 bits of
//   random_value, reads the picked card from the store, moves each card behind
//   it down one slot to close the gap (remaining - 1 - index moves) and loads
//   the output register; the next input beat is taken once the sequencer is
//   back in idle. The first draw of a pass first writes one store entry per
//   card (52 x decks) into the card store.
// Reset: rst (synchronous) empties the list and sets the deck count to 1.
// A stalled output holds its beat; a new input beat is taken meanwhile, and its
// result waits in the sequencer until the output register frees.
module deck_shuffle_draw_core #(
  parameter int MAX_DECKS = dsd_pkg::DEF_MAX_DECKS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [dsd_pkg::DECK_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dsd_pkg::RAND_W-1:0] random_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dsd_pkg::RANK_W-1:0] card_rank,
  output logic [dsd_pkg::SUIT_W-1:0] card_suit,
  output logic                       pass_done
);
  import dsd_pkg::*;

  dsd_cmd_t    cmd;
  dsd_status_t st;

  // Sequencer
  dsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Card store and arithmetic
  dsd_datapath #(
    .MAX_DECKS (MAX_DECKS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .random_value (random_value),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .card_rank    (card_rank),
    .card_suit    (card_suit),
    .pass_done    (pass_done)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the deck shuffle draw core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dsd_pkg::*;

  localparam int MAX_DECKS   = DEF_MAX_DECKS;
  localparam int DECK_SLOTS  = MAX_DECKS * CARDS_PER_DECK;
  localparam int SETTLE_CYC  = 2 * DECK_SLOTS + 60;

  typedef struct {
    card_t card;
    logic  last;
  } drawn_card_t;

  // Track the cards still in play and the draws owed by the block
  class card_draw_tracker;
    card_t             cards_in_play[DECK_SLOTS];
    int unsigned       cards_left;
    logic [DECK_W-1:0] deck_setting;
    drawn_card_t       draws_due[$];
    int unsigned       mismatch_count;

    function new();
      cards_left     = 0;
      deck_setting   = DECK_W'(1);
      mismatch_count = 0;
    endfunction

    function void set_deck_count(input logic [DECK_W-1:0] value);
      deck_setting = value;
    endfunction

    // Lay out the ordered decks, clamping the deck count into range
    function void refill();
      int unsigned decks;
      int unsigned p;
      int unsigned q;
      decks = deck_setting;
      if (decks == 0) decks = 1;
      if (decks > MAX_DECKS) decks = MAX_DECKS;
      for (p = 0; p < decks * CARDS_PER_DECK; p++) begin
        q = p % CARDS_PER_DECK;
        cards_in_play[p].rank = RANK_W'(q % RANKS);
        cards_in_play[p].suit = SUIT_W'((q / RANKS) % SUITS);
      end
      cards_left = decks * CARDS_PER_DECK;
    endfunction

    // Pull the chosen card and close the gap behind it
    function void note_draw(input logic [RAND_W-1:0] pick);
      int unsigned idx;
      int unsigned p;
      drawn_card_t d;
      if (cards_left == 0) refill();
      idx    = pick % cards_left;
      d.card = cards_in_play[idx];
      for (p = idx; p + 1 < cards_left; p++) cards_in_play[p] = cards_in_play[p + 1];
      cards_left--;
      d.last = (cards_left == 0);
      draws_due = {draws_due, d};
    endfunction

    function void check_card(input logic [RANK_W-1:0] rank, input logic [SUIT_W-1:0] suit,
                             input logic last);
      drawn_card_t d;
      if (draws_due.size() == 0) begin
        $display("%0t: card with none due: expected none, got rank %0d suit %0d last %0b",
                 $time, rank, suit, last);
        mismatch_count++;
        return;
      end
      d = draws_due.pop_front();
      if (d.card.rank !== rank) begin
        $display("%0t: card_rank mismatch: expected %0d, got %0d", $time, d.card.rank, rank);
        mismatch_count++;
      end
      if (d.card.suit !== suit) begin
        $display("%0t: card_suit mismatch: expected %0d, got %0d", $time, d.card.suit, suit);
        mismatch_count++;
      end
      if (d.last !== last) begin
        $display("%0t: pass_done mismatch: expected %0b, got %0b", $time, d.last, last);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return draws_due.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [DECK_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [RAND_W-1:0] random_value;
  logic              out_valid;
  logic              out_stall;
  logic [RANK_W-1:0] card_rank;
  logic [SUIT_W-1:0] card_suit;
  logic              pass_done;

  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       hold_cycles;
  card_draw_tracker  tracker;

  deck_shuffle_draw_core #(.MAX_DECKS(MAX_DECKS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .random_value (random_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .card_rank    (card_rank),
    .card_suit    (card_suit),
    .pass_done    (pass_done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Note accepted draw beats, then check accepted card beats
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_draw(random_value);
      if (out_valid && !out_stall) tracker.check_card(card_rank, card_suit, pass_done);
    end
  end

  // Drive the output stall: a long hold-off when asked, otherwise random
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall   = 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  // Bias toward the extremes and toward small picks
  function automatic logic [RAND_W-1:0] pick_random_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return RAND_W'($urandom_range(0, DECK_SLOTS + 3));
      default: return RAND_W'($urandom);
    endcase
  endfunction

  // Offer one draw beat; entered and left at a falling edge
  task automatic send_draw(input logic [RAND_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    random_value = value;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off new draws until every owed card is out and the core settles
  task automatic wait_drained();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_deck_count(input logic [DECK_W-1:0] value);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    tracker.set_deck_count(value);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic run_phase(input logic [DECK_W-1:0] decks, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned n_draws,
                           input int unsigned hold);
    write_deck_count(decks);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold > 0) begin
      @(posedge clk);
      hold_cycles = hold;
      @(negedge clk);
    end
    repeat (n_draws) send_draw(pick_random_value());
  endtask

  // Abort a hung run
  initial begin
    #60_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    tracker        = new();
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    random_value   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset deck count, extreme picks, last slot, first slot
    send_draw('0);
    send_draw('1);
    send_draw(RAND_W'(CARDS_PER_DECK - 3));
    send_draw(RAND_W'(1));
    send_draw(31'h4000_0000);
    send_draw(31'h5555_5555);
    send_draw(31'h2AAA_AAAA);
    send_draw(RAND_W'(CARDS_PER_DECK - 8));
    send_draw(31'h7FFF_FFFE);
    send_draw(RAND_W'(CARDS_PER_DECK));
    // Change the deck count mid-pass; the pass must keep its single deck
    write_deck_count(4'd15);
    send_draw('1);
    send_draw('0);
    send_draw(31'h0000_FFFF);
    send_draw(31'h7FFF_0000);
    send_draw(RAND_W'(CARDS_PER_DECK - 15));
    send_draw(RAND_W'(5));
    send_draw(31'h1234_5678);
    send_draw(31'h6DB6_DB6D);
    send_draw('1);
    send_draw('0);

    // Random phases across deck counts and idling patterns
    run_phase(4'd0,  0,  0,  130, 0);
    run_phase(4'd3,  71, 0,  130, 0);
    run_phase(4'd15, 0,  71, 200, 3000);
    run_phase(4'd10, 36, 36, 480, 0);
    run_phase(4'd5,  0,  0,  100, 0);

    // Drain, then let the core settle before the verdict
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
